FILE: sv/led_matrix_frame_with_rotation_unit_macros.svh
// Assertion helpers shared by the frame unit modules.
// Both expect clk and rst_n in the scope where they are used.
`ifndef LED_MATRIX_FRAME_WITH_ROTATION_UNIT_MACROS_SVH
`define LED_MATRIX_FRAME_WITH_ROTATION_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LMFR_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LMFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lmfr_pkg.sv
package lmfr_pkg;

    // Display controller register addresses.
    localparam logic [3:0] ADDR_DECODE    = 4'd9;
    localparam logic [3:0] ADDR_INTENSITY = 4'd10;
    localparam logic [3:0] ADDR_SCANLIMIT = 4'd11;
    localparam logic [3:0] ADDR_SHUTDOWN  = 4'd12;
    localparam logic [3:0] ADDR_TEST      = 4'd15;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROTATION   = 2'd0;
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd1;

    localparam logic [7:0] BRIGHT_LIMIT = 8'd16;
    localparam logic [2:0] LAST_LANE    = 3'd7;

    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_QUERY  = 3'd1,
        OP_ROW    = 3'd2,
        OP_COL    = 3'd3,
        OP_INVERT = 3'd4,
        OP_CLEAR  = 3'd5,
        OP_INIT   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ROT_LEFT   = 2'd0,
        ROT_TOP    = 2'd1,
        ROT_RIGHT  = 2'd2,
        ROT_BOTTOM = 2'd3
    } rot_t;

    // Datapath action of one microcode step.
    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_PIXEL,
        ACT_QUERY,
        ACT_INVERT,
        ACT_CLEAR,
        ACT_CONST,
        ACT_INTENS
    } act_t;

    // Where a pixel step takes its row, column and value from.
    typedef enum logic [1:0] {
        PIX_ITEM,
        PIX_ROW,
        PIX_COL
    } pix_src_t;

    typedef enum logic {
        SEQ_NEXT,
        SEQ_LOOP
    } seq_t;

    // Program counter values.
    localparam logic [3:0] PC_SET       = 4'd0;
    localparam logic [3:0] PC_QUERY     = 4'd1;
    localparam logic [3:0] PC_ROW       = 4'd2;
    localparam logic [3:0] PC_COL       = 4'd3;
    localparam logic [3:0] PC_INVERT    = 4'd4;
    localparam logic [3:0] PC_CLEAR     = 4'd5;
    localparam logic [3:0] PC_INIT      = 4'd6;
    localparam logic [3:0] PC_SCANLIMIT = 4'd7;
    localparam logic [3:0] PC_DECODE    = 4'd8;
    localparam logic [3:0] PC_BLANK     = 4'd9;
    localparam logic [3:0] PC_INTENS    = 4'd10;
    localparam logic [3:0] PC_SHUTDOWN  = 4'd11;
    localparam logic [3:0] LAST_PC      = PC_SHUTDOWN;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] row;
        logic [2:0] column;
        logic       pixel_on;
        logic [7:0] line_value;
    } in_t;

    typedef struct packed {
        logic       is_command;
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       pixel_lit;
        logic       last;
    } out_t;

    typedef struct packed {
        act_t       act;
        pix_src_t   src;
        seq_t       seq;
        logic       last;
        logic [3:0] addr;
        logic [7:0] data;
    } ctl_t;

    // Control from the sequencer to the datapath for the current step.
    typedef struct packed {
        logic       fire;
        logic       emit;
        logic       done;
        logic [2:0] count;
        ctl_t       ctl;
    } step_t;

    typedef struct packed {
        logic [2:0] idx;
        logic [2:0] bit_no;
        logic [3:0] addr;
    } loc_t;

    // Microcode ROM.
    function automatic ctl_t ucode(input logic [3:0] pc);
        ctl_t c;
        c = '{act: ACT_NOP, src: PIX_ITEM, seq: SEQ_NEXT, last: 1'b1,
              addr: 4'd0, data: 8'd0};
        unique case (pc)
            PC_SET:       begin c.act = ACT_PIXEL; end
            PC_QUERY:     begin c.act = ACT_QUERY; end
            PC_ROW:       begin c.act = ACT_PIXEL; c.src = PIX_ROW; c.seq = SEQ_LOOP; end
            PC_COL:       begin c.act = ACT_PIXEL; c.src = PIX_COL; c.seq = SEQ_LOOP; end
            PC_INVERT:    begin c.act = ACT_INVERT; c.seq = SEQ_LOOP; end
            PC_CLEAR:     begin c.act = ACT_CLEAR; c.seq = SEQ_LOOP; end
            PC_INIT:
            begin
                c.act = ACT_CONST; c.last = 1'b0; c.addr = ADDR_TEST; c.data = 8'd0;
            end
            PC_SCANLIMIT:
            begin
                c.act = ACT_CONST; c.last = 1'b0; c.addr = ADDR_SCANLIMIT; c.data = 8'd7;
            end
            PC_DECODE:
            begin
                c.act = ACT_CONST; c.last = 1'b0; c.addr = ADDR_DECODE; c.data = 8'd0;
            end
            PC_BLANK:     begin c.act = ACT_CLEAR; c.seq = SEQ_LOOP; c.last = 1'b0; end
            PC_INTENS:    begin c.act = ACT_INTENS; c.last = 1'b0; end
            PC_SHUTDOWN:
            begin
                c.act = ACT_CONST; c.addr = ADDR_SHUTDOWN; c.data = 8'd1;
            end
            default:      begin c.act = ACT_NOP; end
        endcase
        return c;
    endfunction

    // Map a pixel to its store byte, bit and digit register for a mounting side.
    function automatic loc_t locate(input logic [1:0] rot, input logic [2:0] r,
                                    input logic [2:0] c);
        loc_t l;
        unique case (rot_t'(rot))
            ROT_LEFT:   l = '{idx: r, bit_no: LAST_LANE - c, addr: {1'b0, r} + 4'd1};
            ROT_TOP:    l = '{idx: c, bit_no: LAST_LANE - r, addr: 4'd8 - {1'b0, c}};
            ROT_RIGHT:  l = '{idx: LAST_LANE - r, bit_no: c, addr: 4'd8 - {1'b0, r}};
            ROT_BOTTOM: l = '{idx: c, bit_no: r, addr: {1'b0, c} + 4'd1};
            default:    l = '{idx: r, bit_no: LAST_LANE - c, addr: {1'b0, r} + 4'd1};
        endcase
        return l;
    endfunction

endpackage

FILE: sv/led_matrix_frame_with_rotation_unit.sv
// The first result of an operation passes the sequencer registers and then the output register.
// Throughput: one microcode step per cycle while the output register can take it, each step
// giving at most one output word; stalls on the output hold the sequencer.
// An unused opcode is taken and dropped. The single microcode step loop sets the rate.
// Reset (rst_n, asynchronous, active low) clears the frame store, both configuration registers,
// the sequencer and the output valid flag; no clearing pass is needed.
module led_matrix_frame_with_rotation_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lmfr_pkg::in_t       in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lmfr_pkg::out_t      out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    // Configuration registers. Writes to indexes beyond the two registers are dropped.
    logic [1:0]      rotation_reg;
    logic [7:0]      brightness_reg;

    logic            in_xfer;
    logic            seq_idle;
    logic            out_free;
    logic            bright_low;
    lmfr_pkg::step_t step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg   <= 2'd0;
            brightness_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lmfr_pkg::CFG_ROTATION)
            begin
                rotation_reg <= cfg_data[1:0];
            end
            else if (cfg_index == lmfr_pkg::CFG_BRIGHTNESS)
            begin
                brightness_reg <= cfg_data;
            end
        end
    end

    // The block takes a new operation whenever the sequencer has finished the last one;
    // a finished result may still be waiting in the output register at that time.
    assign in_ready   = seq_idle;
    assign in_xfer    = in_valid && in_ready;
    // The intensity command of init is only sent for brightness values below 16.
    assign bright_low = brightness_reg < lmfr_pkg::BRIGHT_LIMIT;

    // The sequencer walks the microcode program for the operation, one step per cycle,
    // and holds a step whose command cannot yet enter the output register.
    lmfr_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_xfer),
        .opcode     (in_data.opcode),
        .bright_low (bright_low),
        .out_free   (out_free),
        .idle       (seq_idle),
        .step       (step)
    );

    // The datapath keeps the frame store, builds each command word from the step's
    // control word and registers it for the output transfer.
    lmfr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_item  (in_xfer),
        .item       (in_data),
        .rotation   (rotation_reg),
        .brightness (brightness_reg),
        .step       (step),
        .out_ready  (out_ready),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

FILE: sv/lmfr_seq.sv
`include "led_matrix_frame_with_rotation_unit_macros.svh"

// Microcode sequencer: program counter, lane counter and step dispatch.
module lmfr_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          opcode,
    input  logic                bright_low,
    input  logic                out_free,
    output logic                idle,
    output lmfr_pkg::step_t     step
);

    logic                busy_reg, busy_next;
    logic [3:0]          pc_reg, pc_next;
    logic [2:0]          i_reg, i_next;
    logic                entry_ok;
    logic [3:0]          entry_pc;
    lmfr_pkg::ctl_t      ctl;
    logic                loop_more;

    always_comb
    begin
        entry_ok = 1'b1;
        entry_pc = lmfr_pkg::PC_SET;
        unique case (opcode)
            lmfr_pkg::OP_SET:    entry_pc = lmfr_pkg::PC_SET;
            lmfr_pkg::OP_QUERY:  entry_pc = lmfr_pkg::PC_QUERY;
            lmfr_pkg::OP_ROW:    entry_pc = lmfr_pkg::PC_ROW;
            lmfr_pkg::OP_COL:    entry_pc = lmfr_pkg::PC_COL;
            lmfr_pkg::OP_INVERT: entry_pc = lmfr_pkg::PC_INVERT;
            lmfr_pkg::OP_CLEAR:  entry_pc = lmfr_pkg::PC_CLEAR;
            lmfr_pkg::OP_INIT:   entry_pc = lmfr_pkg::PC_INIT;
            default:             entry_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        ctl       = lmfr_pkg::ucode(pc_reg);
        loop_more = (ctl.seq == lmfr_pkg::SEQ_LOOP) && (i_reg != lmfr_pkg::LAST_LANE);

        step.ctl   = ctl;
        step.count = i_reg;
        // The intensity step is skipped when the brightness is out of range.
        step.emit  = (ctl.act != lmfr_pkg::ACT_NOP)
                     && !((ctl.act == lmfr_pkg::ACT_INTENS) && !bright_low);
        step.fire  = busy_reg && (!step.emit || out_free);
        step.done  = ctl.last && !loop_more;

        busy_next = busy_reg;
        pc_next   = pc_reg;
        i_next    = i_reg;
        if (start && entry_ok)
        begin
            busy_next = 1'b1;
            pc_next   = entry_pc;
            i_next    = 3'd0;
        end
        else if (step.fire)
        begin
            if (loop_more)
            begin
                i_next = i_reg + 3'd1;
            end
            else
            begin
                i_next = 3'd0;
                if (ctl.last)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    pc_next = pc_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= lmfr_pkg::PC_SET;
            i_reg    <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            i_reg    <= i_next;
        end
    end

    assign idle = !busy_reg;

    `LMFR_ASSERT_NEXT(a_done_goes_idle, step.fire && step.done, !busy_reg, "sequencer still busy after final step")
    `LMFR_ASSERT(a_pc_in_program, busy_reg, pc_reg <= lmfr_pkg::LAST_PC, "program counter beyond the program")
    `LMFR_ASSERT_NEXT(a_lane_advance, step.fire && (ctl.seq == lmfr_pkg::SEQ_LOOP) && (i_reg != lmfr_pkg::LAST_LANE), i_reg == $past(i_reg) + 3'd1, "lane counter did not advance")

endmodule

FILE: sv/lmfr_dp.sv
`include "led_matrix_frame_with_rotation_unit_macros.svh"

// Datapath: item register, frame store, command formation and output register.
module lmfr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_item,
    input  lmfr_pkg::in_t       item,
    input  logic [1:0]          rotation,
    input  logic [7:0]          brightness,
    input  lmfr_pkg::step_t     step,
    input  logic                out_ready,
    output logic                out_free,
    output logic                out_valid,
    output lmfr_pkg::out_t      out_data
);

    lmfr_pkg::in_t   item_reg;
    logic [7:0]      store_reg [8];
    logic            out_valid_reg;
    lmfr_pkg::out_t  out_data_reg;

    logic [2:0]      pr, pc;
    logic            pon;
    lmfr_pkg::loc_t  loc;
    logic [7:0]      cur_byte, mask, new_byte;
    logic            wr_en;
    logic [2:0]      wr_idx;
    logic [7:0]      wr_val;
    lmfr_pkg::out_t  res;
    logic            load_out;

    always_comb
    begin
        pr  = item_reg.row;
        pc  = item_reg.column;
        pon = item_reg.pixel_on;
        unique case (step.ctl.src)
            lmfr_pkg::PIX_ROW:
            begin
                pc  = step.count;
                pon = item_reg.line_value[lmfr_pkg::LAST_LANE - step.count];
            end
            lmfr_pkg::PIX_COL:
            begin
                pr  = step.count;
                pon = item_reg.line_value[lmfr_pkg::LAST_LANE - step.count];
            end
            default: ;
        endcase

        loc      = lmfr_pkg::locate(rotation, pr, pc);
        cur_byte = store_reg[loc.idx];
        mask     = 8'd1 << loc.bit_no;
        new_byte = pon ? (cur_byte | mask) : (cur_byte & ~mask);

        wr_en  = 1'b0;
        wr_idx = step.count;
        wr_val = 8'd0;
        res    = '{is_command: 1'b1, reg_address: {1'b0, step.count} + 4'd1,
                   reg_data: 8'd0, pixel_lit: 1'b0, last: step.done};
        unique case (step.ctl.act)
            lmfr_pkg::ACT_PIXEL:
            begin
                wr_en           = 1'b1;
                wr_idx          = loc.idx;
                wr_val          = new_byte;
                res.reg_address = loc.addr;
                res.reg_data    = new_byte;
            end
            lmfr_pkg::ACT_QUERY:
            begin
                res.is_command  = 1'b0;
                res.reg_address = 4'd0;
                res.pixel_lit   = cur_byte[loc.bit_no];
            end
            lmfr_pkg::ACT_INVERT:
            begin
                wr_en        = 1'b1;
                wr_val       = ~store_reg[step.count];
                res.reg_data = wr_val;
            end
            lmfr_pkg::ACT_CLEAR:
            begin
                wr_en = 1'b1;
            end
            lmfr_pkg::ACT_CONST:
            begin
                res.reg_address = step.ctl.addr;
                res.reg_data    = step.ctl.data;
            end
            lmfr_pkg::ACT_INTENS:
            begin
                res.reg_address = lmfr_pkg::ADDR_INTENSITY;
                res.reg_data    = brightness;
            end
            default: ;
        endcase

        load_out = step.fire && step.emit;
        wr_en    = wr_en && load_out;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= item;
        end
        if (load_out)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 8; k++)
            begin
                store_reg[k] <= 8'd0;
            end
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                store_reg[wr_idx] <= wr_val;
            end
        end
    end

    `LMFR_ASSERT(a_query_is_last, out_valid_reg && !out_data_reg.is_command, out_data_reg.last && (out_data_reg.reg_address == 4'd0), "query answer malformed")
    `LMFR_ASSERT(a_no_overwrite, out_valid_reg && !out_ready, !load_out, "result overwritten while waiting")

endmodule
